@@ sv/msr_pkg.sv @@
package msr_pkg;

   // Default number of motor channels.
   localparam int CHANNELS_DEF = 7;

   // Depth of the command queue between front and back.
   localparam int CMD_DEPTH = 2;

   // Depth of the result queue in front of the result ports.
   localparam int RSP_DEPTH = 4;

   // Fixed field widths of the request and response beats.
   localparam int OP_W    = 2;
   localparam int CHAN_W  = 3;
   localparam int VALUE_W = 8;
   localparam int DUTY_W  = 8;

   // Request operation codes.
   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 2'd0,
      OP_SPEED = 2'd1,
      OP_DIR   = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // Command handed from the front to the back. For a direction write the
   // value is already reduced to a single reverse bit in bit 0.
   typedef struct packed {
      op_type               op;
      logic [CHAN_W-1:0]    channel;
      logic [VALUE_W-1:0]   value;
   } cmd_type;

   // One result beat.
   typedef struct packed {
      logic [CHAN_W-1:0]    out_channel;
      logic [DUTY_W-1:0]    duty;
      logic                 reverse;
      logic                 last;
   } rsp_type;

   // Status of a queue as seen by its neighbors.
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

@@ sv/msr_queue.sv @@
module msr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [WIDTH-1:0]   wdata,
   input  logic               pop,
   output logic [WIDTH-1:0]   rdata,
   output msr_pkg::qstat_type stat
);
   import msr_pkg::*;

   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   // Status and the head entry, shown as long as the queue holds a beat.
   assign stat.full  = (count_ff == CNTW'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign rdata      = mem_ff[rd_ptr_ff];

   assign do_push = push && !stat.full;
   assign do_pop  = pop && !stat.empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      unique case ({do_push, do_pop})
         2'b10: begin
            count_in = count_ff + CNTW'(1);
         end
         2'b01: begin
            count_in = count_ff - CNTW'(1);
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ sv/msr_front.sv @@
module msr_front #(
   parameter int CHANNELS = msr_pkg::CHANNELS_DEF
) (
   input  logic                        req_push,
   input  logic [msr_pkg::OP_W-1:0]    req_op,
   input  logic [msr_pkg::CHAN_W-1:0]  req_channel,
   input  logic [msr_pkg::VALUE_W-1:0] req_value,
   output logic                        req_full,
   input  msr_pkg::qstat_type          cmd_stat,
   output logic                        cmd_push,
   output msr_pkg::cmd_type            cmd_data
);
   import msr_pkg::*;

   logic   accept;
   logic   keep;
   op_type op;

   // A beat is taken whenever the command queue has room.
   assign req_full = cmd_stat.full;
   assign accept   = req_push && !req_full;
   assign op       = op_type'(req_op);

   // Classify the beat: ticks always go on, writes only to a channel that
   // exists, and the unused code is dropped here.
   always_comb begin
      keep             = 1'b0;
      cmd_data.op      = op;
      cmd_data.channel = req_channel;
      cmd_data.value   = req_value;
      unique case (op)
         OP_TICK: begin
            keep = 1'b1;
         end
         OP_SPEED: begin
            keep = (32'(req_channel) < CHANNELS);
         end
         OP_DIR: begin
            keep           = (32'(req_channel) < CHANNELS);
            cmd_data.value = {{(VALUE_W - 1){1'b0}}, |req_value};
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign cmd_push = accept && keep;

endmodule

@@ sv/msr_back.sv @@
module msr_back #(
   parameter int CHANNELS = msr_pkg::CHANNELS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  msr_pkg::cmd_type   cmd_data,
   input  msr_pkg::qstat_type cmd_stat,
   output logic               cmd_pop,
   input  msr_pkg::qstat_type rsp_stat,
   output logic               rsp_push,
   output msr_pkg::rsp_type   rsp_data
);
   import msr_pkg::*;

   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic {
      ST_IDLE,
      ST_TICK
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     ch_ff, ch_in;
   logic [DUTY_W-1:0] target_speed_ff    [CHANNELS];
   logic [DUTY_W-1:0] target_speed_in    [CHANNELS];
   logic              target_reverse_ff  [CHANNELS];
   logic              target_reverse_in  [CHANNELS];
   logic [DUTY_W-1:0] applied_duty_ff    [CHANNELS];
   logic [DUTY_W-1:0] applied_duty_in    [CHANNELS];
   logic              applied_reverse_ff [CHANNELS];
   logic              applied_reverse_in [CHANNELS];

   logic [CW-1:0]     wr_idx;
   logic [DUTY_W-1:0] duty_cur, speed_cur, duty_next;
   logic              rev_cur, trev_cur, rev_next;
   logic              at_last;

   assign wr_idx  = CW'(cmd_data.channel);
   assign at_last = (ch_ff == CW'(CHANNELS - 1));

   // Ramp step for the channel under the counter.
   always_comb begin
      duty_cur  = applied_duty_ff[ch_ff];
      rev_cur   = applied_reverse_ff[ch_ff];
      speed_cur = target_speed_ff[ch_ff];
      trev_cur  = target_reverse_ff[ch_ff];
      duty_next = duty_cur;
      rev_next  = rev_cur;
      priority if (rev_cur != trev_cur) begin
         if (duty_cur != '0) begin
            duty_next = duty_cur - DUTY_W'(1);
         end else begin
            rev_next = trev_cur;
         end
      end else if (duty_cur < speed_cur) begin
         duty_next = duty_cur + DUTY_W'(1);
      end else if (duty_cur > speed_cur) begin
         duty_next = duty_cur - DUTY_W'(1);
      end
   end

   // Result beat for the channel under the counter.
   assign rsp_data.out_channel = CHAN_W'(ch_ff);
   assign rsp_data.duty        = duty_next;
   assign rsp_data.reverse     = rev_next;
   assign rsp_data.last        = at_last;

   // Sequencer: writes are applied as they are popped, a tick walks all channels.
   always_comb begin
      state_in           = state_ff;
      ch_in              = ch_ff;
      target_speed_in    = target_speed_ff;
      target_reverse_in  = target_reverse_ff;
      applied_duty_in    = applied_duty_ff;
      applied_reverse_in = applied_reverse_ff;
      cmd_pop            = 1'b0;
      rsp_push           = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_stat.empty) begin
               cmd_pop = 1'b1;
               unique case (cmd_data.op)
                  OP_SPEED: begin
                     target_speed_in[wr_idx] = cmd_data.value;
                  end
                  OP_DIR: begin
                     target_reverse_in[wr_idx] = cmd_data.value[0];
                  end
                  OP_TICK: begin
                     state_in = ST_TICK;
                     ch_in    = '0;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_TICK: begin
            if (!rsp_stat.full) begin
               rsp_push                  = 1'b1;
               applied_duty_in[ch_ff]    = duty_next;
               applied_reverse_in[ch_ff] = rev_next;
               if (at_last) begin
                  state_in = ST_IDLE;
               end else begin
                  ch_in = ch_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         ch_ff              <= '0;
         target_speed_ff    <= '{default: '0};
         target_reverse_ff  <= '{default: 1'b0};
         applied_duty_ff    <= '{default: '0};
         applied_reverse_ff <= '{default: 1'b0};
      end else begin
         state_ff           <= state_in;
         ch_ff              <= ch_in;
         target_speed_ff    <= target_speed_in;
         target_reverse_ff  <= target_reverse_in;
         applied_duty_ff    <= applied_duty_in;
         applied_reverse_ff <= applied_reverse_in;
      end
   end

endmodule

@@ sv/multi_channel_speed_ramp_unit.sv @@
// Channel    Direction  Handshake          Beat
// req_       in         push / full        op, channel, value
// rsp_       out        empty / pop        out_channel, duty, reverse, last
//
// A write beat is applied in the back end as it is popped; a tick takes the
// command, then walks the channels one by one with the single shared ramp
// step on the channel counter.
// Synchronous reset clears all targets, applied duties and directions.
// The command queue lets new beats in while a tick runs; the result queue
// holds finished beats, and the back end pauses when it is full.
module multi_channel_speed_ramp_unit #(
   parameter int CHANNELS = msr_pkg::CHANNELS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [msr_pkg::OP_W-1:0]    req_op,
   input  logic [msr_pkg::CHAN_W-1:0]  req_channel,
   input  logic [msr_pkg::VALUE_W-1:0] req_value,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [msr_pkg::CHAN_W-1:0]  rsp_out_channel,
   output logic [msr_pkg::DUTY_W-1:0]  rsp_duty,
   output logic                        rsp_reverse,
   output logic                        rsp_last
);
   import msr_pkg::*;

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   cmd_type    cmd_wdata, cmd_rdata;
   logic       cmd_push, cmd_pop;
   qstat_type  cmd_stat;
   rsp_type    rsp_wdata, rsp_rdata;
   logic       rsp_push;
   qstat_type  rsp_stat;
   logic [CMD_W-1:0] cmd_rvec;
   logic [RSP_W-1:0] rsp_rvec;

   // Front end: takes and classifies request beats.
   msr_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .req_push    (req_push),
      .req_op      (req_op),
      .req_channel (req_channel),
      .req_value   (req_value),
      .req_full    (req_full),
      .cmd_stat    (cmd_stat),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_wdata)
   );

   // Command queue between the two halves.
   msr_queue #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wdata),
      .pop   (cmd_pop),
      .rdata (cmd_rvec),
      .stat  (cmd_stat)
   );

   assign cmd_rdata = cmd_type'(cmd_rvec);

   // Back end: holds the channel state and runs the ramp.
   msr_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_data (cmd_rdata),
      .cmd_stat (cmd_stat),
      .cmd_pop  (cmd_pop),
      .rsp_stat (rsp_stat),
      .rsp_push (rsp_push),
      .rsp_data (rsp_wdata)
   );

   // Result queue in front of the response ports.
   msr_queue #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wdata),
      .pop   (rsp_pop),
      .rdata (rsp_rvec),
      .stat  (rsp_stat)
   );

   assign rsp_rdata       = rsp_type'(rsp_rvec);
   assign rsp_empty       = rsp_stat.empty;
   assign rsp_out_channel = rsp_rdata.out_channel;
   assign rsp_duty        = rsp_rdata.duty;
   assign rsp_reverse     = rsp_rdata.reverse;
   assign rsp_last        = rsp_rdata.last;

endmodule

@@ sv/msr_checker.sv @@
module msr_checker #(
   parameter int CHANNELS = msr_pkg::CHANNELS_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_empty,
   input logic                        rsp_pop,
   input logic [msr_pkg::CHAN_W-1:0]  rsp_out_channel,
   input logic                        rsp_last
);
   import msr_pkg::*;

   // No result is pending right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result shown right after reset");

   // The last flag marks the final channel only.
   a_last_channel: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_last) |-> (32'(rsp_out_channel) == CHANNELS - 1))
      else $error("last flag on a channel other than the final one");

   // Within a tick, the beat after a taken one is for the next channel.
   a_channel_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_last) |=>
      (rsp_empty || rsp_out_channel == CHAN_W'($past(rsp_out_channel) + CHAN_W'(1))))
      else $error("channels out of order within a tick");

   // After the final channel, the next tick starts again at channel zero.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && rsp_last) |=>
      (rsp_empty || rsp_out_channel == '0))
      else $error("tick does not start at channel zero");

endmodule

bind multi_channel_speed_ramp_unit msr_checker #(
   .CHANNELS (CHANNELS)
) u_msr_checker (.*);

@@ tb/sv/multi_channel_speed_ramp_unit_test.sv @@
`timescale 1ns / 1ps

module multi_channel_speed_ramp_unit_test;
   import msr_pkg::*;

   localparam int CHANNELS     = CHANNELS_DEF;
   localparam int RANDOM_BEATS = 480;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_push    = 1'b0;
   logic                req_full;
   logic [OP_W-1:0]     req_op      = OP_TICK;
   logic [CHAN_W-1:0]   req_channel = '0;
   logic [VALUE_W-1:0]  req_value   = '0;
   logic                rsp_empty;
   logic                rsp_pop     = 1'b0;
   logic [CHAN_W-1:0]   rsp_out_channel;
   logic [DUTY_W-1:0]   rsp_duty;
   logic                rsp_reverse;
   logic                rsp_last;

   int cycle_count = 0;
   int stall_left  = 0;
   int burst_left  = 0;

   // Tracks the targets and applied outputs of every channel and holds the
   // duty beats that the ticks seen so far must produce, oldest first.
   class ramp_board;
      logic [DUTY_W-1:0] goal_speed   [CHANNELS];
      logic              goal_reverse [CHANNELS];
      logic [DUTY_W-1:0] duty_now     [CHANNELS];
      logic              reverse_now  [CHANNELS];
      rsp_type           due_beats[$];
      int                mismatches;

      function new();
         for (int i = 0; i < CHANNELS; i++) begin
            goal_speed[i]   = '0;
            goal_reverse[i] = 1'b0;
            duty_now[i]     = '0;
            reverse_now[i]  = 1'b0;
         end
         mismatches = 0;
      endfunction

      // A pending reversal first winds the duty down to zero and flips the
      // direction on the tick that finds it there; otherwise the duty moves
      // one step toward the target speed.
      function void ramp_channel(int ch);
         if (reverse_now[ch] != goal_reverse[ch]) begin
            if (duty_now[ch] != '0)
               duty_now[ch] = duty_now[ch] - 1'b1;
            else
               reverse_now[ch] = goal_reverse[ch];
         end else if (duty_now[ch] < goal_speed[ch]) begin
            duty_now[ch] = duty_now[ch] + 1'b1;
         end else if (duty_now[ch] > goal_speed[ch]) begin
            duty_now[ch] = duty_now[ch] - 1'b1;
         end
      endfunction

      // Applies one accepted request beat. Writes past the last channel and
      // the unused op code change nothing.
      function void take_command(op_type op, logic [CHAN_W-1:0] ch,
                                 logic [VALUE_W-1:0] value);
         rsp_type beat;
         case (op)
            OP_SPEED: begin
               if (ch < CHANNELS)
                  goal_speed[ch] = value;
            end
            OP_DIR: begin
               if (ch < CHANNELS)
                  goal_reverse[ch] = (value != '0);
            end
            OP_TICK: begin
               for (int i = 0; i < CHANNELS; i++) begin
                  ramp_channel(i);
                  beat.out_channel = CHAN_W'(i);
                  beat.duty        = duty_now[i];
                  beat.reverse     = reverse_now[i];
                  beat.last        = (i == CHANNELS - 1);
                  due_beats.push_back(beat);
               end
            end
            default: ;
         endcase
      endfunction

      task report(string line);
         mismatches++;
         $display("%0t ns: %s", $time, line);
      endtask

      // Compares one accepted result beat with the oldest expected one.
      task check_beat(rsp_type got);
         rsp_type want;
         if (due_beats.size() == 0) begin
            report($sformatf("unexpected result beat for channel %0d", got.out_channel));
            return;
         end
         want = due_beats.pop_front();
         if (got.out_channel != want.out_channel)
            report($sformatf("out_channel %0d, expected %0d",
                             got.out_channel, want.out_channel));
         if (got.duty != want.duty)
            report($sformatf("channel %0d: duty %0d, expected %0d",
                             want.out_channel, got.duty, want.duty));
         if (got.reverse != want.reverse)
            report($sformatf("channel %0d: reverse %0d, expected %0d",
                             want.out_channel, got.reverse, want.reverse));
         if (got.last != want.last)
            report($sformatf("channel %0d: last %0d, expected %0d",
                             want.out_channel, got.last, want.last));
      endtask

      function int pending();
         return due_beats.size();
      endfunction
   endclass

   ramp_board board;

   multi_channel_speed_ramp_unit DUT (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_op          (req_op),
      .req_channel     (req_channel),
      .req_value       (req_value),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_channel (rsp_out_channel),
      .rsp_duty        (rsp_duty),
      .rsp_reverse     (rsp_reverse),
      .rsp_last        (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Cycle counter and watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("multi_channel_speed_ramp_unit regression: fail");
         $finish;
      end
   end

   // Both handshakes are sampled at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full)
            board.take_command(op_type'(req_op), req_channel, req_value);
         if (rsp_pop && !rsp_empty)
            board.check_beat(rsp_type'({rsp_out_channel, rsp_duty, rsp_reverse, rsp_last}));
      end
   end

   // The receiver pops freely while cycle_count[9:8] is zero, takes short
   // stalls while it is one or two and long ones while it is three.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_pop = 1'b0;
         stall_left--;
      end else if (cycle_count[9:8] == 2'd0) begin
         rsp_pop = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
         rsp_pop = 1'b0;
         stall_left = $urandom_range(0, (cycle_count[9:8] == 2'd3) ? 24 : 4);
      end else begin
         rsp_pop = 1'b1;
      end
   end

   // Holds one request beat on the ports until it is taken.
   task send_beat(op_type op, logic [CHAN_W-1:0] ch, logic [VALUE_W-1:0] value);
      req_op      = op;
      req_channel = ch;
      req_value   = value;
      req_push    = 1'b1;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Sends beats in bursts of random length; most bursts follow a gap.
   task send_paced(op_type op, logic [CHAN_W-1:0] ch, logic [VALUE_W-1:0] value);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_push = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      send_beat(op, ch, value);
   endtask

   // Draws one random beat and tells whether it does anything.
   task send_random(output bit counted);
      int                 pick;
      logic [CHAN_W-1:0]  ch;
      logic [VALUE_W-1:0] value;
      pick  = $urandom_range(0, 99);
      ch    = ($urandom_range(0, 15) == 0) ? CHAN_W'($urandom)
                                           : CHAN_W'($urandom_range(0, CHANNELS - 1));
      value = VALUE_W'($urandom);
      counted = 1'b1;
      if (pick < 45) begin
         send_paced(OP_TICK, ch, value);
      end else if (pick < 75) begin
         // Small targets let the duties settle and cross them often.
         if ($urandom_range(0, 3) != 0)
            value = VALUE_W'($urandom_range(0, 12));
         counted = (ch < CHANNELS);
         send_paced(OP_SPEED, ch, value);
      end else if (pick < 95) begin
         if ($urandom_range(0, 1) == 0)
            value = '0;
         counted = (ch < CHANNELS);
         send_paced(OP_DIR, ch, value);
      end else begin
         counted = 1'b0;
         send_paced(OP_NONE, ch, value);
      end
   endtask

   initial begin
      int  done;
      bit  counted;
      board = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed beats: ignored fields on a tick, the unused op code,
      // writes past the last channel, and reversals at zero and nonzero duty.
      send_paced(OP_TICK, 3'd7, 8'hFF);
      send_paced(OP_NONE, 3'd3, 8'hFF);
      send_paced(OP_SPEED, 3'd0, 8'hFF);
      send_paced(OP_SPEED, 3'd6, 8'd1);
      send_paced(OP_SPEED, 3'd7, 8'd200);
      send_paced(OP_TICK, 3'd0, 8'd0);
      send_paced(OP_TICK, 3'd5, 8'hAA);
      send_paced(OP_DIR, 3'd0, 8'h80);
      send_paced(OP_DIR, 3'd6, 8'd1);
      send_paced(OP_DIR, 3'd7, 8'd1);
      send_paced(OP_DIR, 3'd3, 8'hFF);
      send_paced(OP_TICK, 3'd0, 8'd0);
      send_paced(OP_TICK, 3'd0, 8'd0);
      send_paced(OP_TICK, 3'd0, 8'd0);
      send_paced(OP_TICK, 3'd0, 8'd0);
      send_paced(OP_DIR, 3'd0, 8'd0);
      send_paced(OP_SPEED, 3'd5, 8'hAA);
      send_paced(OP_SPEED, 3'd1, 8'h55);
      send_paced(OP_DIR, 3'd3, 8'd0);
      send_paced(OP_TICK, 3'd2, 8'h0F);
      send_paced(OP_TICK, 3'd4, 8'hF0);
      send_paced(OP_NONE, 3'd0, 8'd0);
      send_paced(OP_TICK, 3'd1, 8'd1);

      // Random beats; ignored writes do not count toward the total.
      done = 0;
      while (done < RANDOM_BEATS) begin
         send_random(counted);
         if (counted)
            done++;
      end
      req_push = 1'b0;

      while (board.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0)
         $display("multi_channel_speed_ramp_unit regression: pass");
      else
         $display("multi_channel_speed_ramp_unit regression: fail");
      $finish;
   end

endmodule
